### sv/sed_pkg.sv
package sed_pkg;

    localparam int unsigned DEF_DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    // what the shift-subtract core reports back to the control
    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_core_stat;

endpackage

### sv/sed_if.sv
interface sed_in_if #(
    parameter int unsigned DATA_WIDTH = sed_pkg::DEF_DATA_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface sed_out_if #(
    parameter int unsigned DATA_WIDTH = sed_pkg::DEF_DATA_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quotient;
    logic        [1:0]            status;

    modport source (output valid, output quotient, output status, input ready);
    modport sink   (input valid, input quotient, input status, output ready);
endinterface

### sv/sed_core.sv
module sed_core #(
    parameter int unsigned DATA_WIDTH = sed_pkg::DEF_DATA_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DATA_WIDTH-1:0]  i_dividend_mag,
    input  logic [DATA_WIDTH-1:0]  i_divisor_mag,
    output sed_pkg::t_core_stat    o_stat,
    output logic [DATA_WIDTH-1:0]  o_quo
);
    import sed_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_quo, n_quo;
    logic [DATA_WIDTH-1:0] r_div, n_div;
    logic [DATA_WIDTH:0]   trial;

    // one quotient bit per cycle: dividend bits shift out at the top of r_quo,
    // quotient bits shift in at the bottom
    assign trial = {r_rem, r_quo[DATA_WIDTH-1]} - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DATA_WIDTH);
            n_rem  = '0;
            n_quo  = i_dividend_mag;
            n_div  = i_divisor_mag;
        end else if (r_busy) begin
            if (!trial[DATA_WIDTH]) begin
                n_rem = trial[DATA_WIDTH-1:0];
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DATA_WIDTH-2:0], r_quo[DATA_WIDTH-1]};
                n_quo = {r_quo[DATA_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = |r_rem;
    assign o_quo         = r_quo;

endmodule

### sv/signed_euclidean_divider.sv
// signed euclidean divider: quotient such that the remainder is never negative
// input channel i_in carries dividend and divisor; output channel o_out carries
// quotient and a 2-bit status (ok, division by zero, overflow saturated)
// one beat in gives exactly one beat out, in order
// the restoring shift-subtract core resolves one quotient bit a cycle; the round-up
// of the magnitude is then registered, and sign and saturation are applied as the
// result is loaded into the output register
// one item at a time: i_in.ready is high while no item is in work
// the finished result sits in an output register; the next item is accepted
// while it waits, and only the final load stalls if o_out.ready stays low
// a zero divisor gives quotient 0 with division-by-zero status; most negative
// divided by minus one gives the largest positive value with overflow status
// reset (synchronous, active low) empties the block: no result pending, ready high
module signed_euclidean_divider #(
    parameter int unsigned DATA_WIDTH = sed_pkg::DEF_DATA_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sed_in_if.sink          i_in,
    sed_out_if.source       o_out
);
    import sed_pkg::*;

    t_state                       r_state, n_state;
    logic                         r_a_neg, n_a_neg;
    logic                         r_b_neg, n_b_neg;
    logic                         r_b_zero, n_b_zero;
    logic [DATA_WIDTH-1:0]        r_qmag, n_qmag;
    logic                         r_out_valid, n_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_q, n_out_q;
    t_status                      r_out_st, n_out_st;

    logic                  start;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    t_core_stat            core_stat;
    logic [DATA_WIDTH-1:0] core_quo;

    // two's complement magnitudes fit W unsigned bits, most negative included
    assign a_mag = i_in.dividend[DATA_WIDTH-1] ? DATA_WIDTH'(-i_in.dividend)
                                                : DATA_WIDTH'(i_in.dividend);
    assign b_mag = i_in.divisor[DATA_WIDTH-1]  ? DATA_WIDTH'(-i_in.divisor)
                                                : DATA_WIDTH'(i_in.divisor);

    sed_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_dividend_mag (a_mag),
        .i_divisor_mag  (b_mag),
        .o_stat         (core_stat),
        .o_quo          (core_quo)
    );

    always_comb begin
        n_state     = r_state;
        n_a_neg     = r_a_neg;
        n_b_neg     = r_b_neg;
        n_b_zero    = r_b_zero;
        n_qmag      = r_qmag;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_q     = r_out_q;
        n_out_st    = r_out_st;
        i_in.ready  = 1'b0;
        start       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    start    = 1'b1;
                    n_a_neg  = i_in.dividend[DATA_WIDTH-1];
                    n_b_neg  = i_in.divisor[DATA_WIDTH-1];
                    n_b_zero = (b_mag == '0);
                    n_state  = ST_DIV;
                end
            end
            ST_DIV: begin
                if (core_stat.done) begin
                    // negative dividend with a remainder rounds the magnitude up
                    n_qmag  = core_quo + DATA_WIDTH'(r_a_neg && core_stat.rem_nz);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (r_b_zero) begin
                        n_out_q  = '0;
                        n_out_st = STATUS_DIV_ZERO;
                    end else if (!(r_a_neg ^ r_b_neg) && r_qmag[DATA_WIDTH-1]) begin
                        n_out_q  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
                        n_out_st = STATUS_OVERFLOW;
                    end else begin
                        n_out_q  = (r_a_neg ^ r_b_neg) ? -$signed(r_qmag)
                                                       : $signed(r_qmag);
                        n_out_st = STATUS_OK;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_neg  <= n_a_neg;
        r_b_neg  <= n_b_neg;
        r_b_zero <= n_b_zero;
        r_qmag   <= n_qmag;
        r_out_q  <= n_out_q;
        r_out_st <= n_out_st;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.quotient = r_out_q;
    assign o_out.status   = r_out_st;

endmodule

### sv/sed_checker.sv
module sed_checker #(
    parameter int unsigned DATA_WIDTH = sed_pkg::DEF_DATA_WIDTH
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic signed [DATA_WIDTH-1:0] i_quotient,
    input logic        [1:0]            i_status
);
    import sed_pkg::*;

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_quotient) && $stable(i_status))
        else $error("stalled result changed");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second beat taken while busy");

    a_div_zero_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STATUS_DIV_ZERO |-> i_quotient == '0)
        else $error("division by zero with non-zero quotient");

    a_overflow_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == STATUS_OVERFLOW |->
            i_quotient == {1'b0, {(DATA_WIDTH-1){1'b1}}})
        else $error("overflow without saturation");

endmodule

bind signed_euclidean_divider sed_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_sed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_quotient  (o_out.quotient),
    .i_status    (o_out.status)
);

### bench/signed_euclidean_divider_tb.sv
module signed_euclidean_divider_tb;

    import sed_pkg::*;

    localparam int W            = DEF_DATA_WIDTH;
    localparam int CLK_PERIOD   = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 3 * (W + 2);
    localparam int N_PHASE      = 510;
    localparam int N_DIR        = 25;

    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};

    typedef struct packed {
        logic signed [W-1:0] quotient;
        t_status             status;
    } t_quot_beat;

    typedef struct packed {
        logic signed [W-1:0] dividend;
        logic signed [W-1:0] divisor;
        logic                typed;
        logic signed [W-1:0] quotient;
        t_status             status;
    } t_div_row;

    // typed quotients only on the rows that can be read off directly
    t_div_row div_rows [0:N_DIR-1] = '{
        '{0,      1,      1'b1, 0,         STATUS_OK},
        '{7,      2,      1'b0, 0,         STATUS_OK},
        '{-7,     2,      1'b0, 0,         STATUS_OK},
        '{7,      -2,     1'b0, 0,         STATUS_OK},
        '{-7,     -2,     1'b0, 0,         STATUS_OK},
        '{-8,     2,      1'b0, 0,         STATUS_OK},
        '{0,      -5,     1'b0, 0,         STATUS_OK},
        '{5,      0,      1'b1, 0,         STATUS_DIV_ZERO},
        '{0,      0,      1'b1, 0,         STATUS_DIV_ZERO},
        '{S_MIN,  0,      1'b1, 0,         STATUS_DIV_ZERO},
        '{S_MAX,  0,      1'b1, 0,         STATUS_DIV_ZERO},
        '{S_MIN,  -1,     1'b1, S_MAX,     STATUS_OVERFLOW},
        '{S_MIN,  1,      1'b1, S_MIN,     STATUS_OK},
        '{S_MAX,  1,      1'b1, S_MAX,     STATUS_OK},
        '{S_MAX,  -1,     1'b1, S_MIN + 1, STATUS_OK},
        '{S_MAX,  S_MAX,  1'b1, 1,         STATUS_OK},
        '{S_MIN,  S_MIN,  1'b1, 1,         STATUS_OK},
        '{S_MIN,  S_MAX,  1'b0, 0,         STATUS_OK},
        '{S_MAX,  S_MIN,  1'b0, 0,         STATUS_OK},
        '{-1,     S_MIN,  1'b0, 0,         STATUS_OK},
        '{-1,     S_MAX,  1'b0, 0,         STATUS_OK},
        '{1,      S_MIN,  1'b0, 0,         STATUS_OK},
        '{S_MIN,  2,      1'b0, 0,         STATUS_OK},
        '{S_MIN,  -2,     1'b0, 0,         STATUS_OK},
        '{-1,     -1,     1'b1, 1,         STATUS_OK}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic rx_ready = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    logic       next_typed = 1'b0;
    t_quot_beat next_typed_beat = '0;

    t_quot_beat pending_quotients [$];
    int n_fail    = 0;
    int n_checked = 0;
    int n_div0    = 0;
    int n_ovf     = 0;
    int n_random  = 0;

    sed_in_if  #(.DATA_WIDTH(W)) in_if ();
    sed_out_if #(.DATA_WIDTH(W)) out_if ();

    assign out_if.ready = rx_ready;

    signed_euclidean_divider #(.DATA_WIDTH(W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // work on 33-bit magnitudes so the most negative value negates cleanly
    function automatic t_quot_beat euclid_quotient(input logic signed [W-1:0] num,
                                                   input logic signed [W-1:0] den);
        logic [W:0] num_mag;
        logic [W:0] den_mag;
        logic [W:0] q_mag;
        logic [W:0] q_neg_mag;
        logic       num_neg;
        logic       den_neg;
        t_quot_beat r;
        num_neg = num[W-1];
        den_neg = den[W-1];
        num_mag = num_neg ? ({(W+1){1'b0}} - {num[W-1], num}) : {1'b0, num};
        den_mag = den_neg ? ({(W+1){1'b0}} - {den[W-1], den}) : {1'b0, den};
        r.quotient = '0;
        r.status   = STATUS_DIV_ZERO;
        if (den_mag == '0)
            return r;
        q_mag = num_mag / den_mag;
        // round the magnitude up so the remainder stays non-negative
        if (num_neg && (num_mag % den_mag) != '0)
            q_mag = q_mag + 1'b1;
        if (num_neg == den_neg && q_mag > {2'b00, {(W-1){1'b1}}}) begin
            r.quotient = S_MAX;
            r.status   = STATUS_OVERFLOW;
        end else begin
            q_neg_mag  = {(W+1){1'b0}} - q_mag;
            r.quotient = (num_neg != den_neg) ? q_neg_mag[W-1:0] : q_mag[W-1:0];
            r.status   = STATUS_OK;
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] edge_value();
        case ($urandom_range(0, 5))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return S_MIN + 1;
        endcase
    endfunction

    function automatic void pick_operands(output logic signed [W-1:0] num,
                                          output logic signed [W-1:0] den);
        int                  sel;
        logic signed [W-1:0] q;
        sel = $urandom_range(0, 19);
        num = $urandom;
        den = $urandom;
        if (sel >= 6 && sel <= 8) begin
            num = $urandom_range(0, 200) - 100;
            den = $urandom_range(0, 40) - 20;
        end else if (sel == 9) begin
            den = 0;
        end else if (sel <= 11 && sel >= 10) begin
            num = edge_value();
        end else if (sel <= 13 && sel >= 12) begin
            den = edge_value();
            if (den == 0)
                den = $urandom_range(0, 1) ? 2 : -2;
        end else if (sel >= 14 && sel <= 16) begin
            // exact multiples: dividends of either sign with no remainder
            den = $urandom_range(1, 1000);
            if ($urandom_range(0, 1))
                den = -den;
            q   = $signed($urandom) >>> $urandom_range(10, W - 1);
            num = q * den;
        end else if (sel >= 17) begin
            num = $signed($urandom) >>> $urandom_range(0, W - 1);
            den = $signed($urandom) >>> $urandom_range(0, W - 1);
        end
    endfunction

    task automatic note_failure(input string what);
        n_fail++;
        if (n_fail <= 10)
            $display("mismatch: %s", what);
    endtask

    task automatic offer(input logic signed [W-1:0] num, input logic signed [W-1:0] den,
                         input logic typed, input t_quot_beat typed_beat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.dividend  <= num;
        in_if.divisor   <= den;
        next_typed      <= typed;
        next_typed_beat <= typed_beat;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // the last beat's expectation is queued at its accept edge, so wait for the next edge before looking
    task automatic drain_quotients();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_quotients.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        logic signed [W-1:0] num;
        logic signed [W-1:0] den;
        for (int k = 0; k < count; k++) begin
            pick_operands(num, den);
            offer(num, den, 1'b0, '0);
            n_random++;
        end
    endtask

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            rx_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else begin
            rx_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // expectation is pushed before the pop so ordering within the edge is fixed
    always @(posedge i_clk) begin
        t_quot_beat want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                pending_quotients.push_back(next_typed ? next_typed_beat
                                            : euclid_quotient(in_if.dividend, in_if.divisor));
            if (out_if.valid && out_if.ready) begin
                if (pending_quotients.size() == 0) begin
                    note_failure($sformatf("unexpected beat quotient %0d status %0d",
                                           out_if.quotient, out_if.status));
                end else begin
                    want = pending_quotients.pop_front();
                    n_checked++;
                    if (want.status == STATUS_DIV_ZERO)
                        n_div0++;
                    if (want.status == STATUS_OVERFLOW)
                        n_ovf++;
                    if (out_if.quotient !== want.quotient || out_if.status !== want.status)
                        note_failure($sformatf("quotient %0d status %0d, expected %0d status %0d",
                                               out_if.quotient, out_if.status,
                                               want.quotient, want.status));
                end
            end
        end
    end

    initial begin
        in_if.valid    = 1'b0;
        in_if.dividend = '0;
        in_if.divisor  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 29;
        recv_idle_pct <= 87;
        for (int k = 0; k < N_DIR; k++)
            offer(div_rows[k].dividend, div_rows[k].divisor, div_rows[k].typed,
                  '{div_rows[k].quotient, div_rows[k].status});
        run_random(N_PHASE);
        drain_quotients();

        send_idle_pct = 87;
        recv_idle_pct <= 29;
        run_random(N_PHASE);
        drain_quotients();

        // no idling; the long hold-off fills the output register and stalls the input
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_seq <= hold_seq + 1;
        run_random(N_PHASE - N_DIR + 30);
        drain_quotients();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_quotients.size() != 0)
            note_failure($sformatf("%0d quotients never arrived", pending_quotients.size()));

        $display("divided %0d directed and %0d random operand pairs, %0d quotients checked",
                 N_DIR, n_random, n_checked);
        $display("%0d by zero, %0d saturated, %0d failures", n_div0, n_ovf, n_fail);
        if (n_fail == 0) begin
            $display("[signed_euclidean_divider] OK");
        end else begin
            $display("[signed_euclidean_divider] ERROR");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 1000000);
        $display("timed out");
        $display("[signed_euclidean_divider] ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/sed_pkg.sv
sv/sed_if.sv
sv/sed_core.sv
sv/signed_euclidean_divider.sv
sv/sed_checker.sv
bench/signed_euclidean_divider_tb.sv
